// File: rtl/vhc_pkg.sv
// Package: shared types and constants for the varint frame classifier.
`timescale 1ns / 1ps

package vhc_pkg;

  localparam int unsigned FRAME_COUNT_BITS_DEF = 22;
  localparam int unsigned MAX_VARINT_BYTES     = 5;
  localparam int unsigned VARINT_W             = 32;
  localparam int unsigned LEN_W                = 22;
  localparam int unsigned VCNT_W               = 3;

  localparam logic [VARINT_W-1:0] HARD_MAX_FRAME = VARINT_W'(2 * 1024 * 1024);
  localparam logic [LEN_W-1:0]    LEN_SAT        = '1;
  localparam logic [LEN_W-1:0]    MAX_LEN_RESET  = LEN_W'(2 * 1024 * 1024);

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_PKT_ID  = 3'd1,
    PH_PROTO   = 3'd2,
    PH_ADDRLEN = 3'd3,
    PH_SKIP    = 3'd4,
    PH_NEXT    = 3'd5,
    PH_TRAIL   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    VERDICT_STATUS    = 2'd0,
    VERDICT_OTHER     = 2'd1,
    VERDICT_MALFORMED = 2'd2,
    VERDICT_REJECTED  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } in_item_t;

  typedef struct packed {
    verdict_t                    verdict;
    logic signed [VARINT_W-1:0]  protocol_version;
    logic signed [VARINT_W-1:0]  req_state;
    logic [LEN_W-1:0]            host_len;
    logic [LEN_W-1:0]            frm_len;
  } out_item_t;

  typedef logic [LEN_W-1:0] cfg_item_t;

endpackage

// File: rtl/vhc_stream_if.sv
// Interface: valid/ready channel carrying one payload item per transfer.
`timescale 1ns / 1ps

interface vhc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/varint_handshake_classifier.sv
// Top level: varint length-prefixed handshake frame classifier.
//
//   channel | dir | payload                                   | transfer when
//   --------+-----+-------------------------------------------+---------------
//   in_if   | in  | data_byte, new_connection                 | valid & ready
//   out_if  | out | verdict, protocol_version, req_state,     | valid & ready
//           |     | host_len, frm_len                         |
//   cfg_if  | in  | max_frame_length (22 bits)                | valid & ready
//
// One byte per cycle sustained while the result register is not stalled. A byte
// waits in the input register, is decoded against the parse state in one pass
// and its verdict lands in the result register, which offers it on out_if.
// Reset (rst_n low, synchronous) clears the parse state and sets the maximum
// frame length to 2 MiB. A stalled result register holds the pass; the input
// register still takes one byte, then ready drops until the result moves.
`timescale 1ns / 1ps

module varint_handshake_classifier import vhc_pkg::*; #(
  parameter int unsigned FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  vhc_stream_if.sink    in_if,
  vhc_stream_if.source  out_if,
  vhc_stream_if.sink    cfg_if
);

  localparam int unsigned FC_W = FRAME_COUNT_BITS;

  // Configuration
  logic [LEN_W-1:0] max_len_r;

  // Input register
  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       proc;

  // Parse state
  phase_t                phase_r, phase_nxt, phase_step;
  logic [VARINT_W-1:0]   acc_r, acc_nxt;
  logic [VCNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FC_W-1:0]       left_r, left_nxt;
  logic [FC_W-1:0]       skip_r, skip_nxt;
  logic [VARINT_W-1:0]   proto_r, proto_nxt;
  logic [VARINT_W-1:0]   nstate_r, nstate_nxt;
  logic [LEN_W-1:0]      addr_r, addr_nxt;
  logic [LEN_W-1:0]      flen_r, flen_nxt;
  logic                  mal_r, mal_nxt;
  logic                  halt_r, halt_nxt;

  // State as seen by this byte (cleared on a new connection)
  phase_t                phase_e;
  logic [VARINT_W-1:0]   acc_e;
  logic [VCNT_W-1:0]     cnt_e;
  logic [FC_W-1:0]       left_e;
  logic [FC_W-1:0]       skip_e;
  logic [VARINT_W-1:0]   proto_e;
  logic [VARINT_W-1:0]   nstate_e;
  logic [LEN_W-1:0]      addr_e;
  logic [LEN_W-1:0]      flen_e;
  logic                  mal_e;
  logic                  halt_e;

  // Decode
  logic [7:0]            b;
  logic [5:0]            shamt;
  logic [VARINT_W-1:0]   v;
  logic                  vdone, vlong, vend;
  logic                  varint_phase;
  logic                  reject;
  logic                  v_zero;
  logic [VARINT_W:0]     addr_sum;
  logic [FC_W-1:0]       left_dec;
  logic [FC_W-1:0]       skip_dec;
  logic                  pkt_bad, addr_bad;
  logic                  last_byte;
  logic                  mal_step;

  // Result
  logic                  emit;
  out_item_t             res;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  // ---------------------------------------------------------------------------
  // Configuration register
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_if.valid) begin
      max_len_r <= cfg_if.payload;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  assign proc        = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_item_r <= in_if.payload;
    end
  end

  // ---------------------------------------------------------------------------
  // Effective state: a new connection clears everything but the register
  always_comb begin
    if (s1_item_r.new_connection) begin
      phase_e  = PH_LEN;
      acc_e    = '0;
      cnt_e    = '0;
      left_e   = '0;
      skip_e   = '0;
      proto_e  = '0;
      nstate_e = '0;
      addr_e   = '0;
      flen_e   = '0;
      mal_e    = 1'b0;
      halt_e   = 1'b0;
    end else begin
      phase_e  = phase_r;
      acc_e    = acc_r;
      cnt_e    = cnt_r;
      left_e   = left_r;
      skip_e   = skip_r;
      proto_e  = proto_r;
      nstate_e = nstate_r;
      addr_e   = addr_r;
      flen_e   = flen_r;
      mal_e    = mal_r;
      halt_e   = halt_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Varint step and checks
  always_comb begin
    b     = s1_item_r.data_byte;
    // place the 7-bit group at 7 * byte index, top group keeps its low 4 bits
    shamt = {cnt_e, 3'b000} - {3'b000, cnt_e};
    v     = acc_e | ({25'd0, b[6:0]} << shamt);
    vdone = !b[7];
    vlong = b[7] && (cnt_e == VCNT_W'(MAX_VARINT_BYTES - 1));
    vend  = vdone || vlong;

    varint_phase = phase_e inside {PH_PKT_ID, PH_PROTO, PH_ADDRLEN, PH_NEXT};

    reject = vlong || v[VARINT_W-1] || (v > HARD_MAX_FRAME) ||
             (v > VARINT_W'(max_len_r)) || ((v >> FRAME_COUNT_BITS) != '0);
    v_zero = (v == '0);

    left_dec = FC_W'(left_e - 1'b1);
    skip_dec = FC_W'(skip_e - 1'b1);
    addr_sum = {1'b0, v} + (VARINT_W + 1)'(2);

    pkt_bad  = (phase_e == PH_PKT_ID) && vdone && !v_zero;
    addr_bad = (phase_e == PH_ADDRLEN) && vdone &&
               (v[VARINT_W-1] || (addr_sum > (VARINT_W + 1)'(left_dec)));

    last_byte = !halt_e && (phase_e != PH_LEN) && (left_dec == '0);
    mal_step  = mal_e || (varint_phase && vlong) || pkt_bad || addr_bad;
  end

  // ---------------------------------------------------------------------------
  // Next parse phase
  always_comb begin
    phase_step = phase_e;
    if (!halt_e) begin
      case (phase_e)
        PH_LEN: begin
          if (vend && !reject && !v_zero) phase_step = PH_PKT_ID;
        end
        PH_PKT_ID: begin
          if (vlong || pkt_bad) phase_step = PH_TRAIL;
          else if (vdone)       phase_step = PH_PROTO;
        end
        PH_PROTO: begin
          if (vlong)      phase_step = PH_TRAIL;
          else if (vdone) phase_step = PH_ADDRLEN;
        end
        PH_ADDRLEN: begin
          if (vlong || addr_bad) phase_step = PH_TRAIL;
          else if (vdone)        phase_step = PH_SKIP;
        end
        PH_SKIP: begin
          if (skip_dec == '0) phase_step = PH_NEXT;
        end
        PH_NEXT: begin
          if (vend) phase_step = PH_TRAIL;
        end
        default: phase_step = PH_TRAIL;
      endcase
    end
    phase_nxt = last_byte ? PH_LEN : phase_step;
  end

  // ---------------------------------------------------------------------------
  // Datapath and result
  always_comb begin
    acc_nxt    = acc_e;
    cnt_nxt    = cnt_e;
    left_nxt   = left_e;
    skip_nxt   = skip_e;
    proto_nxt  = proto_e;
    nstate_nxt = nstate_e;
    addr_nxt   = addr_e;
    flen_nxt   = flen_e;
    mal_nxt    = mal_e;
    halt_nxt   = halt_e;
    emit       = 1'b0;
    res        = '0;

    if (!halt_e) begin
      if (phase_e == PH_LEN || varint_phase) begin
        if (vend) begin
          acc_nxt = '0;
          cnt_nxt = '0;
        end else begin
          acc_nxt = v;
          cnt_nxt = VCNT_W'(cnt_e + 1'b1);
        end
      end

      if (phase_e == PH_LEN) begin
        if (vend) begin
          if (reject) begin
            halt_nxt    = 1'b1;
            emit        = 1'b1;
            res.verdict = VERDICT_REJECTED;
            res.frm_len = (v > VARINT_W'(LEN_SAT)) ? LEN_SAT : v[LEN_W-1:0];
          end else begin
            proto_nxt  = '0;
            nstate_nxt = '0;
            addr_nxt   = '0;
            mal_nxt    = 1'b0;
            skip_nxt   = '0;
            flen_nxt   = v[LEN_W-1:0];
            left_nxt   = FC_W'(v);
            if (v_zero) begin
              emit        = 1'b1;
              res.verdict = VERDICT_MALFORMED;
            end
          end
        end
      end else begin
        left_nxt = left_dec;
        mal_nxt  = mal_step;
        if (phase_e == PH_PROTO && vdone) proto_nxt = v;
        if (phase_e == PH_NEXT && vdone)  nstate_nxt = v;
        if (phase_e == PH_ADDRLEN && vdone) begin
          addr_nxt = (v > VARINT_W'(flen_e)) ? flen_e : v[LEN_W-1:0];
          if (!addr_bad) skip_nxt = FC_W'(addr_sum);
        end
        if (phase_e == PH_SKIP) skip_nxt = skip_dec;

        if (last_byte) begin
          emit                 = 1'b1;
          res.protocol_version = proto_nxt;
          res.req_state        = nstate_nxt;
          res.host_len         = addr_nxt;
          res.frm_len          = flen_nxt;
          if (phase_step != PH_TRAIL || mal_step)
            res.verdict = VERDICT_MALFORMED;
          else if (nstate_nxt == VARINT_W'(1))
            res.verdict = VERDICT_STATUS;
          else
            res.verdict = VERDICT_OTHER;
          // drop the frame and restart at the next length
          acc_nxt    = '0;
          cnt_nxt    = '0;
          proto_nxt  = '0;
          nstate_nxt = '0;
          addr_nxt   = '0;
          flen_nxt   = '0;
          mal_nxt    = 1'b0;
          skip_nxt   = '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      acc_r    <= '0;
      cnt_r    <= '0;
      left_r   <= '0;
      skip_r   <= '0;
      proto_r  <= '0;
      nstate_r <= '0;
      addr_r   <= '0;
      flen_r   <= '0;
      mal_r    <= 1'b0;
      halt_r   <= 1'b0;
    end else if (proc) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      skip_r   <= skip_nxt;
      proto_r  <= proto_nxt;
      nstate_r <= nstate_nxt;
      addr_r   <= addr_nxt;
      flen_r   <= flen_nxt;
      mal_r    <= mal_nxt;
      halt_r   <= halt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_item_r <= res;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  a_reject_halts: assert property (@(posedge clk) disable iff (!rst_n)
    proc && emit && (res.verdict == VERDICT_REJECTED) |=> halt_r)
    else $error("rejected length did not halt parsing");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && halt_r && !s1_item_r.new_connection |-> !emit)
    else $error("result produced while halted");

  a_frame_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_LEN |-> left_r != '0)
    else $error("inside a frame with no bytes left");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skip phase with empty skip count");

endmodule

// File: tb/sv/varint_handshake_classifier_tb.sv
// Testbench for the varint frame classifier: directed frames, random streams, checked results.
`timescale 1ns / 1ps

module varint_handshake_classifier_tb;
  import vhc_pkg::*;

  // About 1450 bytes with stalls and drains; the run ends far below this limit.
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [31:0] FRAME_MASK = (32'd1 << FRAME_COUNT_BITS_DEF) - 32'd1;

  typedef enum {VAR_MORE, VAR_DONE, VAR_LONG} varint_status_e;
  typedef enum {
    FR_GOOD, FR_BAD_ID, FR_LONG_VARINT, FR_BAD_ADDR, FR_SHORT, FR_NOISE, FR_HUGE_LEN
  } frame_kind_e;
  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vhc_stream_if #(.T(in_item_t))  in_ch ();
  vhc_stream_if #(.T(out_item_t)) out_ch ();
  vhc_stream_if #(.T(cfg_item_t)) cfg_ch ();

  varint_handshake_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int error_count = 0;
  int checked_count = 0;
  int verdict_seen[4];
  int bytes_sent = 0;
  int bytes_parsed = 0;
  int cycle_count = 0;

  out_item_t  pending_verdicts[$];
  logic [7:0] body_q[$];

  // Classifier state as seen from outside
  logic [21:0] max_len;
  phase_t      ph;
  logic [31:0] vacc;
  int          vcount;
  logic [31:0] left_in_frame;
  logic [31:0] skip_left;
  logic [31:0] kept_proto;
  logic [31:0] kept_next;
  logic [31:0] kept_addr_len;
  logic [31:0] kept_frame_len;
  logic        frame_bad;
  logic        stream_halted;

  function automatic void clear_frame_fields();
    kept_proto = '0;
    kept_next = '0;
    kept_addr_len = '0;
    kept_frame_len = '0;
    frame_bad = 1'b0;
    skip_left = '0;
  endfunction

  function automatic void clear_parse();
    ph = PH_LEN;
    vacc = '0;
    vcount = 0;
    left_in_frame = '0;
    stream_halted = 1'b0;
    clear_frame_fields();
  endfunction

  function automatic varint_status_e feed_varint(input logic [7:0] b, output logic [31:0] val);
    logic [63:0] part;
    part = 64'(b[6:0]) << (7 * (vcount % MAX_VARINT_BYTES));
    vacc = vacc | part[31:0];
    vcount++;
    val = '0;
    if (!b[7] || vcount >= MAX_VARINT_BYTES) begin
      val = vacc;
      vacc = '0;
      vcount = 0;
      return b[7] ? VAR_LONG : VAR_DONE;
    end
    return VAR_MORE;
  endfunction

  // Advance the state by one byte; return 1 when the byte ends a frame or rejects one.
  function automatic bit classify_byte(input logic [7:0] b, input logic nc, output out_item_t res);
    logic [31:0] v;
    varint_status_e r;
    res = '0;
    if (nc) clear_parse();
    if (stream_halted) return 1'b0;
    if (ph == PH_LEN) begin
      r = feed_varint(b, v);
      if (r == VAR_MORE) return 1'b0;
      if (r == VAR_LONG || v[31] || v > HARD_MAX_FRAME || v > 32'(max_len) ||
          v > FRAME_MASK) begin
        stream_halted = 1'b1;
        res.verdict = VERDICT_REJECTED;
        res.frm_len = (v > 32'(LEN_SAT)) ? LEN_SAT : v[LEN_W-1:0];
        return 1'b1;
      end
      clear_frame_fields();
      kept_frame_len = v;
      left_in_frame = v;
      if (v == 32'd0) begin
        res.verdict = VERDICT_MALFORMED;
        return 1'b1;
      end
      ph = PH_PKT_ID;
      return 1'b0;
    end
    left_in_frame = (left_in_frame - 32'd1) & FRAME_MASK;
    case (ph)
      PH_PKT_ID, PH_PROTO, PH_ADDRLEN, PH_NEXT: begin
        r = feed_varint(b, v);
        if (r == VAR_LONG) begin
          frame_bad = 1'b1;
          ph = PH_TRAIL;
        end else if (r == VAR_DONE) begin
          if (ph == PH_PKT_ID) begin
            if (v != 32'd0) begin
              frame_bad = 1'b1;
              ph = PH_TRAIL;
            end else begin
              ph = PH_PROTO;
            end
          end else if (ph == PH_PROTO) begin
            kept_proto = v;
            ph = PH_ADDRLEN;
          end else if (ph == PH_ADDRLEN) begin
            kept_addr_len = (v > kept_frame_len) ? kept_frame_len : v;
            if (v[31] || 33'(v) + 33'd2 > 33'(left_in_frame)) begin
              frame_bad = 1'b1;
              ph = PH_TRAIL;
            end else begin
              skip_left = (v + 32'd2) & FRAME_MASK;
              ph = PH_SKIP;
            end
          end else begin
            kept_next = v;
            ph = PH_TRAIL;
          end
        end
      end
      PH_SKIP: begin
        skip_left = (skip_left - 32'd1) & FRAME_MASK;
        if (skip_left == 32'd0) ph = PH_NEXT;
      end
      default: ph = PH_TRAIL;
    endcase
    if (left_in_frame != 32'd0) return 1'b0;
    if (ph != PH_TRAIL || frame_bad) res.verdict = VERDICT_MALFORMED;
    else res.verdict = (kept_next == 32'd1) ? VERDICT_STATUS : VERDICT_OTHER;
    res.protocol_version = kept_proto;
    res.req_state = kept_next;
    res.host_len = kept_addr_len[LEN_W-1:0];
    res.frm_len = kept_frame_len[LEN_W-1:0];
    ph = PH_LEN;
    vacc = '0;
    vcount = 0;
    clear_frame_fields();
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic nc);
    out_item_t res;
    bit ignored;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= in_item_t'{data_byte: b, new_connection: nc};
    do @(posedge clk); while (!in_ch.ready);
    ignored = stream_halted && !nc;
    if (classify_byte(b, nc, res)) pending_verdicts = {pending_verdicts, res};
    bytes_sent++;
    if (!ignored) bytes_parsed++;
  endtask

  task automatic send_seq(input byte_q_t seq, input logic nc_first);
    foreach (seq[i]) send_byte(seq[i], (i == 0) ? nc_first : 1'b0);
  endtask

  // Pad adds one redundant continuation group where the encoding has room.
  task automatic send_varint(input logic [31:0] v, input logic nc, input bit pad);
    logic [7:0] b;
    logic first;
    int n;
    first = nc;
    n = 0;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      n++;
      if (v != 32'd0) b[7] = 1'b1;
      else if (pad && n < MAX_VARINT_BYTES) b[7] = 1'b1;
      send_byte(b, first);
      first = 1'b0;
    end while (v != 32'd0);
    if (pad && n < MAX_VARINT_BYTES) send_byte(8'h00, 1'b0);
  endtask

  function automatic void add_varint(input logic [31:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 32'd0) b[7] = 1'b1;
      body_q = {body_q, b};
    end while (v != 32'd0);
  endfunction

  function automatic void add_long_varint();
    repeat (MAX_VARINT_BYTES) body_q = {body_q, 8'($urandom) | 8'h80};
  endfunction

  function automatic logic [31:0] pick_wide();
    int roll;
    roll = $urandom_range(3);
    if (roll == 0) return $urandom;
    if (roll == 1) return 32'($urandom_range(127));
    return 32'($urandom_range(128, 100000));
  endfunction

  function automatic logic [31:0] pick_next();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return 32'd1;
    if (roll < 7) return 32'd2;
    if (roll < 8) return 32'($urandom_range(127));
    return $urandom;
  endfunction

  task automatic wait_drain();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_drain();
  endtask

  // Write only with nothing in flight; the extra cycles cover bytes that end no frame.
  task automatic write_max_len(input logic [21:0] val);
    in_ch.valid <= 1'b0;
    wait_drain();
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    max_len = val;
  endtask

  task automatic run_random_frame();
    logic nc;
    int roll;
    int spot;
    int rem;
    int flen;
    int sel;
    frame_kind_e kind;
    logic [31:0] addr;
    nc = stream_halted || ($urandom_range(9) == 0);
    roll = $urandom_range(99);
    if (roll < 60) kind = FR_GOOD;
    else if (roll < 67) kind = FR_BAD_ID;
    else if (roll < 73) kind = FR_LONG_VARINT;
    else if (roll < 79) kind = FR_BAD_ADDR;
    else if (roll < 85) kind = FR_SHORT;
    else if (roll < 92) kind = FR_NOISE;
    else kind = FR_HUGE_LEN;

    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(31) == 0);
      return;
    end
    if (kind == FR_HUGE_LEN) begin
      sel = $urandom_range(3);
      case (sel)
        0: send_varint($urandom, nc, 1'b0);
        1: send_varint(32'(max_len) + 32'($urandom_range(1, 5000)), nc,
                       1'($urandom_range(1)));
        2: begin
          send_byte(8'($urandom) | 8'h80, nc);
          repeat (MAX_VARINT_BYTES - 1) send_byte(8'($urandom) | 8'h80, 1'b0);
        end
        default: send_varint(32'(LEN_SAT) + 32'($urandom_range(0, 3)), nc, 1'b0);
      endcase
      // These land on a halted parser
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
      return;
    end

    body_q.delete();
    spot = (kind == FR_LONG_VARINT) ? $urandom_range(3) : -1;
    if (spot == 0) add_long_varint();
    else add_varint((kind == FR_BAD_ID) ? 32'($urandom_range(1, 300)) : 32'd0);
    if (spot == 1) add_long_varint();
    else add_varint(pick_wide());
    if (kind == FR_BAD_ADDR) begin
      rem = $urandom_range(0, 6);
      if ($urandom_range(3) == 0) addr = $urandom | 32'h80000000;
      else addr = 32'((rem == 0) ? 0 : rem - 1) + 32'($urandom_range(0, 3));
      add_varint(addr);
      repeat (rem) body_q = {body_q, 8'($urandom)};
    end else begin
      addr = ($urandom_range(29) == 0) ? 32'($urandom_range(17, 200)) :
                                         32'($urandom_range(0, 16));
      if (spot == 2) add_long_varint();
      else add_varint(addr);
      repeat (addr + 2) body_q = {body_q, 8'($urandom)};
      if (spot == 3) add_long_varint();
      else add_varint(pick_next());
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) body_q = {body_q, 8'($urandom)};
    end
    flen = body_q.size();
    // Cut the frame short; if only trailing bytes go, the next-state varint still finishes
    if (kind == FR_SHORT) begin
      flen = $urandom_range(1, flen - 1);
      while (body_q.size() > flen) void'(body_q.pop_back());
    end
    send_varint(32'(flen), nc, $urandom_range(3) == 0);
    foreach (body_q[i]) send_byte(body_q[i], $urandom_range(299) == 0);
  endtask

  task automatic run_random_phase(input int n_items, input int snd_pct, input int rcv_pct);
    int start;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      run_random_frame();
      if ($urandom_range(59) == 0) pause_until_drained();
    end
  endtask

  task automatic test_zero_length_frame();
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_status_request();
    send_seq('{8'h06, 8'h00, 8'h7f, 8'h00, 8'hff, 8'h80, 8'h01}, 1'b0);
  endtask

  task automatic test_malformed_frames();
    // address length overruns the frame
    send_seq('{8'h03, 8'h00, 8'h00, 8'h02}, 1'b0);
    // packet id varint never terminates
    send_seq('{8'h05, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80}, 1'b0);
  endtask

  task automatic test_length_rejection();
    // length beyond the frame counter, then a byte on the halted parser
    send_seq('{8'h80, 8'h80, 8'h80, 8'h02}, 1'b0);
    send_byte(8'h00, 1'b0);
    // fifth group keeps its low bits only: negative length
    send_seq('{8'hff, 8'hff, 8'hff, 8'hff, 8'h7f}, 1'b1);
    // exactly 2 MiB is accepted; the next test aborts it
    send_seq('{8'h80, 8'h80, 8'h80, 8'h01}, 1'b1);
  endtask

  task automatic test_max_len_extremes();
    write_max_len(22'd1);
    send_seq('{8'h01, 8'h00}, 1'b1);
    send_byte(8'h02, 1'b0);
    write_max_len(MAX_LEN_RESET);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      checked_count++;
      verdict_seen[int'(got.verdict)]++;
      if (pending_verdicts.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("[%0t] unexpected result: verdict=%0d proto=%0d next=%0d addr=%0d flen=%0d",
                   $time, got.verdict, got.protocol_version, got.req_state,
                   got.host_len, got.frm_len);
      end else begin
        want = pending_verdicts[0];
        pending_verdicts.delete(0);
        if (want.verdict !== got.verdict || want.protocol_version !== got.protocol_version ||
            want.req_state !== got.req_state ||
            want.host_len !== got.host_len ||
            want.frm_len !== got.frm_len) begin
          error_count++;
          if (error_count <= 10) begin
            $display("[%0t] mismatch expected: verdict=%0d proto=%0d next=%0d addr=%0d flen=%0d",
                     $time, want.verdict, want.protocol_version, want.req_state,
                     want.host_len, want.frm_len);
            $display("[%0t]            actual: verdict=%0d proto=%0d next=%0d addr=%0d flen=%0d",
                     $time, got.verdict, got.protocol_version, got.req_state,
                     got.host_len, got.frm_len);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_verdicts.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    max_len = MAX_LEN_RESET;
    clear_parse();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 23;
    rcv_idle_pct = 60;
    test_zero_length_frame();
    test_status_request();
    test_malformed_frames();
    test_length_rejection();
    test_max_len_extremes();

    write_max_len(22'($urandom_range(8, 64)));
    run_random_phase(450, 23, 60);
    write_max_len(22'($urandom_range(12, 40)));
    run_random_phase(450, 60, 23);
    write_max_len(22'($urandom_range(1000, 2097152)));
    run_random_phase(450, 0, 0);

    in_ch.valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes (%0d parsed), checked %0d results: %0d status, %0d other, %0d malformed, %0d rejected",
             bytes_sent, bytes_parsed, checked_count, verdict_seen[0], verdict_seen[1],
             verdict_seen[2], verdict_seen[3]);
    $display("Max frame length set to 1, 2 MiB and three random values; %0d mismatches",
             error_count);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
